// ===== design/writ_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package writ_pkg;

    // phase codes
    localparam logic [1:0] PHASE_READY   = 2'd0;
    localparam logic [1:0] PHASE_WORKING = 2'd1;
    localparam logic [1:0] PHASE_RESTING = 2'd2;

    // alert codes
    localparam logic [1:0] ALERT_NONE      = 2'd0;
    localparam logic [1:0] ALERT_WORK_DONE = 2'd1;
    localparam logic [1:0] ALERT_REST_DONE = 2'd2;
    localparam logic [1:0] ALERT_HEARTBEAT = 2'd3;

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_WORK_LENGTH       = 3'd0;
    localparam logic [2:0] REG_SHORT_REST_LENGTH = 3'd1;
    localparam logic [2:0] REG_LONG_REST_LENGTH  = 3'd2;
    localparam logic [2:0] REG_PERIODS_PER_LONG  = 3'd3;
    localparam logic [2:0] REG_HEARTBEAT_INTVL   = 3'd4;
    localparam logic [2:0] REG_LONG_REST_ENABLE  = 3'd5;
    localparam logic [2:0] REG_HEARTBEAT_ENABLE  = 3'd6;
    localparam logic [2:0] REG_AUTO_CONTINUE     = 3'd7;

    localparam logic [15:0] RST_WORK_LENGTH       = 16'd1500;
    localparam logic [15:0] RST_SHORT_REST_LENGTH = 16'd300;
    localparam logic [15:0] RST_LONG_REST_LENGTH  = 16'd900;
    localparam logic [7:0]  RST_PERIODS_PER_LONG  = 8'd4;
    localparam logic [15:0] RST_HEARTBEAT_INTVL   = 16'd10;

    localparam logic [4:0]  DAY_START_HOUR = 5'd6;
    localparam logic [7:0]  COUNT_MAX      = 8'd255;

    typedef struct packed {
        logic [15:0] work_length;
        logic [15:0] short_rest_length;
        logic [15:0] long_rest_length;
        logic [7:0]  periods_per_long_rest;
        logic [15:0] heartbeat_interval;
        logic        long_rest_enable;
        logic        heartbeat_enable;
        logic        auto_continue;
    } t_cfg;

    typedef struct packed {
        logic done;
        logic is_zero;
    } t_mod_res;

endpackage

`default_nettype wire

// ===== design/writ_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module writ_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output writ_pkg::t_cfg   o_cfg
);
    import writ_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.work_length           <= RST_WORK_LENGTH;
            r_cfg.short_rest_length     <= RST_SHORT_REST_LENGTH;
            r_cfg.long_rest_length      <= RST_LONG_REST_LENGTH;
            r_cfg.periods_per_long_rest <= RST_PERIODS_PER_LONG;
            r_cfg.heartbeat_interval    <= RST_HEARTBEAT_INTVL;
            r_cfg.long_rest_enable      <= 1'b1;
            r_cfg.heartbeat_enable      <= 1'b1;
            r_cfg.auto_continue         <= 1'b0;
        end else if (wr) begin
            case (idx)
                REG_WORK_LENGTH:       r_cfg.work_length           <= pwdata[15:0];
                REG_SHORT_REST_LENGTH: r_cfg.short_rest_length     <= pwdata[15:0];
                REG_LONG_REST_LENGTH:  r_cfg.long_rest_length      <= pwdata[15:0];
                REG_PERIODS_PER_LONG:  r_cfg.periods_per_long_rest <= pwdata[7:0];
                REG_HEARTBEAT_INTVL:   r_cfg.heartbeat_interval    <= pwdata[15:0];
                REG_LONG_REST_ENABLE:  r_cfg.long_rest_enable      <= pwdata[0];
                REG_HEARTBEAT_ENABLE:  r_cfg.heartbeat_enable      <= pwdata[0];
                REG_AUTO_CONTINUE:     r_cfg.auto_continue         <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WORK_LENGTH:       prdata = {16'd0, r_cfg.work_length};
            REG_SHORT_REST_LENGTH: prdata = {16'd0, r_cfg.short_rest_length};
            REG_LONG_REST_LENGTH:  prdata = {16'd0, r_cfg.long_rest_length};
            REG_PERIODS_PER_LONG:  prdata = {24'd0, r_cfg.periods_per_long_rest};
            REG_HEARTBEAT_INTVL:   prdata = {16'd0, r_cfg.heartbeat_interval};
            REG_LONG_REST_ENABLE:  prdata = {31'd0, r_cfg.long_rest_enable};
            REG_HEARTBEAT_ENABLE:  prdata = {31'd0, r_cfg.heartbeat_enable};
            REG_AUTO_CONTINUE:     prdata = {31'd0, r_cfg.auto_continue};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/writ_mod_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
// Only reports whether the remainder is zero; divisor of zero is never started.
module writ_mod_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output writ_pkg::t_mod_res o_res
);
    import writ_pkg::*;

    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_dvd;
    logic [15:0] r_div;

    logic [16:0] trial;
    logic [15:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[15]};
        if (trial >= {1'b0, r_div})
            n_rem = 16'(trial - {1'b0, r_div});
        else
            n_rem = trial[15:0];
    end

    assign o_res.done    = r_busy && (r_cnt == 4'hF);
    assign o_res.is_zero = (n_rem == 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'hF)
                r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 16'd0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[14:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

// ===== design/work_rest_interval_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A button or plain tick passes through ST_FIN into the output register;
//   a modulo (heartbeat check or long-rest check) adds ST_MOD before ST_FIN.
// The FSM holds one item at a time; both checks share the single remainder unit.
// A new item is taken while the previous result still waits on the output register.
// Reset (i_rst_n low, synchronous): phase ready, counters zero, registers to defaults.
module work_rest_interval_timer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [4:0]  i_hour_of_day,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [1:0]  o_phase,
    output logic      [15:0] o_seconds_left,
    output logic      [7:0]  o_completed_count,
    output logic      [1:0]  o_alert,
    output logic             o_backlight_on,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import writ_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic KIND_HEARTBEAT = 1'b0;
    localparam logic KIND_LONG_REST = 1'b1;

    t_cfg     cfg;
    t_mod_res mod_res;

    logic [1:0]  r_state, n_state;
    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_remaining, n_remaining;
    logic [7:0]  r_done, n_done;
    logic [4:0]  r_last_hour, n_last_hour;
    logic [1:0]  r_alert, n_alert;
    logic        r_kind, n_kind;
    logic        r_o_valid;

    logic        mod_start;
    logic [15:0] mod_dvd;
    logic [15:0] mod_div;
    logic [15:0] rem_dec;
    logic [7:0]  cnt_inc;
    logic        load_out;

    writ_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    writ_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (mod_div),
        .o_res      (mod_res)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign load_out = (r_state == ST_FIN) && (!r_o_valid || i_ready);
    assign rem_dec  = r_remaining - 16'd1;
    assign cnt_inc  = (r_done < COUNT_MAX) ? r_done + 8'd1 : r_done;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_done      = r_done;
        n_last_hour = r_last_hour;
        n_alert     = r_alert;
        n_kind      = r_kind;
        mod_start   = 1'b0;
        mod_dvd     = 16'd0;
        mod_div     = 16'd0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_alert = ALERT_NONE;
                    n_state = ST_FIN;
                    if (i_opcode) begin
                        if (r_phase == PHASE_READY) begin
                            n_phase     = PHASE_WORKING;
                            n_remaining = cfg.work_length;
                        end else begin
                            n_phase = PHASE_READY;
                        end
                    end else if (r_phase == PHASE_WORKING || r_phase == PHASE_RESTING) begin
                        if (r_remaining == 16'd0) begin
                            if (r_phase == PHASE_WORKING) begin
                                // day rollover clears the count in place of the increment
                                if (r_last_hour < DAY_START_HOUR &&
                                    i_hour_of_day >= DAY_START_HOUR)
                                    n_done = 8'd0;
                                else
                                    n_done = cnt_inc;
                                n_last_hour = i_hour_of_day;
                                n_alert     = ALERT_WORK_DONE;
                                n_phase     = PHASE_RESTING;
                                n_remaining = cfg.short_rest_length;
                                if (cfg.long_rest_enable &&
                                    cfg.periods_per_long_rest != 8'd0) begin
                                    mod_start = 1'b1;
                                    mod_dvd   = {8'd0, n_done};
                                    mod_div   = {8'd0, cfg.periods_per_long_rest};
                                    n_kind    = KIND_LONG_REST;
                                    n_state   = ST_MOD;
                                end
                            end else begin
                                n_alert = ALERT_REST_DONE;
                                if (cfg.auto_continue) begin
                                    n_phase     = PHASE_WORKING;
                                    n_remaining = cfg.work_length;
                                end else begin
                                    n_phase = PHASE_READY;
                                end
                            end
                        end else begin
                            n_remaining = rem_dec;
                            if (r_phase == PHASE_WORKING && cfg.heartbeat_enable &&
                                cfg.heartbeat_interval != 16'd0) begin
                                mod_start = 1'b1;
                                mod_dvd   = rem_dec;
                                mod_div   = cfg.heartbeat_interval;
                                n_kind    = KIND_HEARTBEAT;
                                n_state   = ST_MOD;
                            end
                        end
                    end
                end
            end
            ST_MOD: begin
                if (mod_res.done) begin
                    n_state = ST_FIN;
                    if (mod_res.is_zero) begin
                        if (r_kind == KIND_HEARTBEAT)
                            n_alert = ALERT_HEARTBEAT;
                        else
                            n_remaining = cfg.long_rest_length;
                    end
                end
            end
            ST_FIN: begin
                if (load_out)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PHASE_READY;
            r_remaining <= 16'd0;
            r_done      <= 8'd0;
            r_last_hour <= 5'd0;
            r_alert     <= ALERT_NONE;
            r_kind      <= KIND_HEARTBEAT;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_done      <= n_done;
            r_last_hour <= n_last_hour;
            r_alert     <= n_alert;
            r_kind      <= n_kind;
            if (load_out)
                r_o_valid <= 1'b1;
            else if (i_ready)
                r_o_valid <= 1'b0;
        end
    end

    // output register, loaded once the previous beat has gone
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_phase           <= r_phase;
            o_seconds_left    <= r_remaining;
            o_completed_count <= r_done;
            o_alert           <= r_alert;
            o_backlight_on    <= (r_alert == ALERT_WORK_DONE) ||
                                 (r_alert == ALERT_REST_DONE);
        end
    end

    assign o_valid = r_o_valid;

endmodule

`default_nettype wire

// ===== design/writ_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module writ_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  o_phase,
    input wire logic [15:0] o_seconds_left,
    input wire logic [1:0]  o_alert,
    input wire logic        o_backlight_on
);
    import writ_pkg::*;

    a_backlight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_backlight_on ==
                     (o_alert == ALERT_WORK_DONE || o_alert == ALERT_REST_DONE)))
        else $error("backlight does not follow alert");

    a_heartbeat_working: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_alert == ALERT_HEARTBEAT) |-> (o_phase == PHASE_WORKING))
        else $error("heartbeat outside working phase");

    a_rest_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_alert == ALERT_REST_DONE) |-> (o_phase != PHASE_RESTING))
        else $error("rest done but still resting");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second beat taken while item in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_seconds_left)))
        else $error("stalled result beat changed");

endmodule

bind work_rest_interval_timer writ_checker u_writ_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_phase        (o_phase),
    .o_seconds_left (o_seconds_left),
    .o_alert        (o_alert),
    .o_backlight_on (o_backlight_on)
);

`default_nettype wire
